[rtl/sha256_pkg.sv]
// ----------------------------------------------------------------------------
// sha256_pkg: SHA-256 constants, types and round functions
// Shared by the byte stream hasher and its round core.
// ----------------------------------------------------------------------------
package sha256_pkg;

  typedef logic [31:0] word_t;

  typedef struct packed {
    logic  start;   // begin compression of the loaded window
    logic  busy;
    logic  done;    // one-cycle pulse; hash words update at its end
  } core_ctl_t;

  function automatic word_t round_const(input logic [5:0] idx);
    word_t k;
    begin
      case (idx)
        6'd0: k = 32'h428a2f98;  6'd1: k = 32'h71374491;  6'd2: k = 32'hb5c0fbcf;
        6'd3: k = 32'he9b5dba5;  6'd4: k = 32'h3956c25b;  6'd5: k = 32'h59f111f1;
        6'd6: k = 32'h923f82a4;  6'd7: k = 32'hab1c5ed5;  6'd8: k = 32'hd807aa98;
        6'd9: k = 32'h12835b01;  6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
        6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe; 6'd14: k = 32'h9bdc06a7;
        6'd15: k = 32'hc19bf174; 6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
        6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc; 6'd20: k = 32'h2de92c6f;
        6'd21: k = 32'h4a7484aa; 6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
        6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d; 6'd26: k = 32'hb00327c8;
        6'd27: k = 32'hbf597fc7; 6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
        6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967; 6'd32: k = 32'h27b70a85;
        6'd33: k = 32'h2e1b2138; 6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
        6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb; 6'd38: k = 32'h81c2c92e;
        6'd39: k = 32'h92722c85; 6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
        6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3; 6'd44: k = 32'hd192e819;
        6'd45: k = 32'hd6990624; 6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
        6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08; 6'd50: k = 32'h2748774c;
        6'd51: k = 32'h34b0bcb5; 6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
        6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3; 6'd56: k = 32'h748f82ee;
        6'd57: k = 32'h78a5636f; 6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
        6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb; 6'd62: k = 32'hbef9a3f7;
        default: k = 32'hc67178f2;
      endcase
      return k;
    end
  endfunction

  function automatic word_t init_hash(input logic [2:0] idx);
    word_t h;
    begin
      case (idx)
        3'd0: h = 32'h6a09e667; 3'd1: h = 32'hbb67ae85;
        3'd2: h = 32'h3c6ef372; 3'd3: h = 32'ha54ff53a;
        3'd4: h = 32'h510e527f; 3'd5: h = 32'h9b05688c;
        3'd6: h = 32'h1f83d9ab; default: h = 32'h5be0cd19;
      endcase
      return h;
    end
  endfunction

  function automatic word_t rotr(input word_t x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  localparam logic [7:0] PAD_BYTE = 8'h80;

endpackage

[rtl/sha256_if.sv]
// ----------------------------------------------------------------------------
// sha256_in_if / sha256_out_if: valid/ready channels of the hasher
// One transfer per clock edge with valid and ready both high.
// ----------------------------------------------------------------------------
interface sha256_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] msg_byte;
  logic       byte_valid;
  logic       last_byte;
  modport source (output valid, msg_byte, byte_valid, last_byte, input ready);
  modport sink (input valid, msg_byte, byte_valid, last_byte, output ready);
endinterface

interface sha256_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word;
  logic [2:0]  word_index;
  logic        last_word;
  modport source (output valid, digest_word, word_index, last_word, input ready);
  modport sink (input valid, digest_word, word_index, last_word, output ready);
endinterface

[rtl/sha256_core.sv]
// ----------------------------------------------------------------------------
// sha256_core: iterative compression, one round per cycle
// Rolling 16-word schedule window; 64 rounds, then all 8 hash adds together.
// ----------------------------------------------------------------------------
module sha256_core (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic                  load_word,  // shift a packed word into window
  input  sha256_pkg::word_t     load_data,
  input  logic                  init,       // restore initial hash
  input  logic [2:0]            hash_sel,
  output sha256_pkg::word_t     hash_out,
  output sha256_pkg::core_ctl_t ctl
);
  import sha256_pkg::*;

  word_t      win [16];
  word_t      hw  [8];
  word_t      v   [8];
  logic [5:0] round;
  logic       busy;
  logic       done;

  word_t w, s0, s1, wn, t1, t2;

  always_comb begin
    s0 = rotr(win[1], 7) ^ rotr(win[1], 18) ^ (win[1] >> 3);
    s1 = rotr(win[14], 17) ^ rotr(win[14], 19) ^ (win[14] >> 10);
    wn = s1 + win[9] + s0 + win[0];
    w  = win[0];
    t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25))
       + ((v[4] & v[5]) ^ (~v[4] & v[6])) + round_const(round) + w;
    t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22))
       + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
  end

  // window shifts on each load and each round; win[0] is W[r], new word enters at win[15]
  always_ff @(posedge clk) begin
    if (load_word || busy) begin
      for (int i = 0; i < 15; i++) win[i] <= win[i + 1];
      win[15] <= load_word ? load_data : wn;
    end
    if (start) begin
      for (int i = 0; i < 8; i++) v[i] <= hw[i];
    end else if (busy) begin
      v[7] <= v[6]; v[6] <= v[5]; v[5] <= v[4]; v[4] <= v[3] + t1;
      v[3] <= v[2]; v[2] <= v[1]; v[1] <= v[0]; v[0] <= t1 + t2;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      round <= '0;
      for (int i = 0; i < 8; i++) hw[i] <= init_hash(3'(i));
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        round <= '0;
      end else if (busy) begin
        round <= round + 6'd1;
        if (round == 6'd63) busy <= 1'b0;
      end else if (done) begin
        for (int i = 0; i < 8; i++) hw[i] <= hw[i] + v[i];
      end else if (init) begin
        for (int i = 0; i < 8; i++) hw[i] <= init_hash(3'(i));
      end
      if (busy && round == 6'd63) done <= 1'b1;
    end
  end

  assign hash_out  = hw[hash_sel];
  assign ctl.start = start;
  assign ctl.busy  = busy;
  assign ctl.done  = done;

endmodule

[rtl/sha256_byte_stream_hasher.sv]
// A byte that fills no block is only written into the buffer; a 64th byte
// then loads the window, runs the rounds and adds the hash. A last item
// adds padding writes from the pad mark to the end of the block, then the
// compression of each final block (one or two), then eight output transfers.
// No overlap: no new bytes are taken while a block is loaded or compressed.
// Reset (rst, synchronous, high): byte count, length and hash restart.
// ----------------------------------------------------------------------------
// sha256_byte_stream_hasher: SHA-256 over a byte stream
// Packs bytes into a 64-byte buffer, pads on the last transfer and streams
// the eight digest words out.
// ----------------------------------------------------------------------------
module sha256_byte_stream_hasher (
  input  logic clk,
  input  logic rst,
  sha256_in_if.sink    in_ch,
  sha256_out_if.source out_ch
);
  import sha256_pkg::*;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_LOAD = 3'd1;  // 16 words into window
  localparam logic [2:0] ST_RUN  = 3'd2;  // wait for core
  localparam logic [2:0] ST_PADF = 3'd3;  // write padding bytes
  localparam logic [2:0] ST_OUT  = 3'd4;

  logic [2:0]  state;
  word_t       buffer [16];       // block as big-endian words, no reset
  logic [5:0]  byte_count;
  logic [63:0] bit_length;
  logic [63:0] total;             // latched message length at padding
  logic        final_pass;        // current block ends the message
  logic        need_second;       // padding spans two blocks
  logic        tail_last;         // 64th byte came with last: pad a fresh block
  logic        pad_mark;          // next padding byte is the 0x80 mark
  logic [5:0]  pad_pos;
  logic [3:0]  load_idx;
  logic [2:0]  out_idx;
  logic        start_core;
  logic        load_word;
  word_t       load_data;
  word_t       hash_out;
  core_ctl_t   ctl;
  logic        out_valid;

  sha256_core u_core (
    .clk(clk), .rst(rst), .start(start_core), .load_word(load_word),
    .load_data(load_data), .init(state == ST_OUT && out_ch.ready && out_idx == 3'd7),
    .hash_sel(out_idx), .hash_out(hash_out), .ctl(ctl)
  );

  assign in_ch.ready = (state == ST_IDLE);
  wire   take        = in_ch.valid && in_ch.ready;

  // one window word per load cycle
  assign load_data  = buffer[load_idx];
  assign load_word  = (state == ST_LOAD);
  assign start_core = load_word && load_idx == 4'd15;

  // padding byte at position pad_pos of the block being closed
  logic [63:0] len_shift;
  logic [7:0]  pad_byte;
  assign len_shift = total >> {3'd7 - pad_pos[2:0], 3'd0};
  always_comb begin
    if (pad_mark)
      pad_byte = PAD_BYTE;
    else if (pad_pos >= 6'd56 && !need_second)
      pad_byte = len_shift[7:0];
    else
      pad_byte = '0;
  end

  // one byte write per cycle: message bytes in idle, padding in ST_PADF
  logic       wr_en;
  logic [5:0] wr_addr;
  logic [7:0] wr_data;
  assign wr_en   = (take && in_ch.byte_valid) || (state == ST_PADF);
  assign wr_addr = (state == ST_PADF) ? pad_pos : byte_count;
  assign wr_data = (state == ST_PADF) ? pad_byte : in_ch.msg_byte;

  always_ff @(posedge clk) begin
    if (wr_en) buffer[wr_addr[5:2]][{~wr_addr[1:0], 3'd0} +: 8] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      byte_count  <= '0;
      bit_length  <= '0;
      final_pass  <= 1'b0;
      need_second <= 1'b0;
      tail_last   <= 1'b0;
      pad_mark    <= 1'b0;
      pad_pos     <= '0;
      load_idx    <= '0;
      out_idx     <= '0;
      total       <= '0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (take) begin
            if (in_ch.byte_valid) begin
              byte_count <= byte_count + 6'd1;
              if (byte_count == 6'd63) begin
                // full block; a last flag pads a fresh block afterwards
                state       <= ST_LOAD;
                load_idx    <= '0;
                final_pass  <= 1'b0;
                need_second <= 1'b0;
                tail_last   <= in_ch.last_byte;
              end else if (in_ch.last_byte) begin
                total       <= bit_length + {55'd0, byte_count + 6'd1, 3'd0};
                state       <= ST_PADF;
                pad_pos     <= byte_count + 6'd1;
                pad_mark    <= 1'b1;
                need_second <= (byte_count + 6'd1) > 6'd55;
                final_pass  <= 1'b0;
              end
            end else if (in_ch.last_byte) begin
              total       <= bit_length + {55'd0, byte_count, 3'd0};
              state       <= ST_PADF;
              pad_pos     <= byte_count;
              pad_mark    <= 1'b1;
              need_second <= byte_count > 6'd55;
              final_pass  <= 1'b0;
            end
          end
        end
        ST_PADF: begin
          pad_mark <= 1'b0;
          if (pad_pos == 6'd63) begin
            state      <= ST_LOAD;
            load_idx   <= '0;
            final_pass <= !need_second;
          end
          pad_pos <= pad_pos + 6'd1;
        end
        ST_LOAD: begin
          load_idx <= load_idx + 4'd1;
          if (load_idx == 4'd15) state <= ST_RUN;
        end
        ST_RUN: begin
          if (ctl.done) begin
            byte_count <= '0;
            if (final_pass) begin
              state   <= ST_OUT;
              out_idx <= '0;
            end else if (need_second) begin
              // length block after a padding overflow
              state       <= ST_PADF;
              pad_pos     <= '0;
              need_second <= 1'b0;
            end else if (tail_last) begin
              bit_length <= bit_length + 64'd512;
              total      <= bit_length + 64'd512;
              state      <= ST_PADF;
              pad_pos    <= '0;
              pad_mark   <= 1'b1;
              tail_last  <= 1'b0;
            end else begin
              bit_length <= bit_length + 64'd512;
              state      <= ST_IDLE;
            end
          end
        end
        ST_OUT: begin
          if (out_ch.ready) begin
            out_idx <= out_idx + 3'd1;
            if (out_idx == 3'd7) begin
              state      <= ST_IDLE;
              bit_length <= '0;
              byte_count <= '0;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  assign out_valid          = (state == ST_OUT);
  assign out_ch.valid       = out_valid;
  assign out_ch.digest_word = hash_out;
  assign out_ch.word_index  = out_idx;
  assign out_ch.last_word   = (out_idx == 3'd7);

endmodule
